FILE: rtl/spoc_pkg.sv
// Shared types and constants of the stack pop-order checker.
// Used by the front queue, the back sequencer and the top level.
package spoc_pkg;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_PUSH = 1'b1;

	localparam int QDEPTH = 2;
	localparam int QAW    = 1;
	localparam int QCW    = 2;

	typedef struct packed {
		logic is_push;
		logic last;
	} op_t;

endpackage

FILE: rtl/spoc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module spoc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/spoc_front.sv
// Front part: accepts input transfers, classifies them as load or push,
// and holds them in a two-entry queue for the back sequencer. Uses spoc_pkg.
module spoc_front import spoc_pkg::*; #(
	parameter int VW = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  logic          kind,
	input  logic [31:0]   value,
	input  logic          last,
	output logic          q_valid,
	output op_t           q_op,
	output logic [VW-1:0] q_value,
	input  logic          q_take
);

	op_t             ent_op_q  [QDEPTH];
	logic [VW-1:0]   ent_val_q [QDEPTH];
	logic [QAW-1:0]  wr_ptr_q;
	logic [QAW-1:0]  rd_ptr_q;
	logic [QCW-1:0]  cnt_q;
	logic            wr_en;
	op_t             in_op;

	assign in_stall = (cnt_q == QCW'(QDEPTH));
	assign wr_en    = in_valid && !in_stall;
	assign q_valid  = (cnt_q != '0);
	assign q_op     = ent_op_q[rd_ptr_q];
	assign q_value  = ent_val_q[rd_ptr_q];

	always_comb begin
		in_op.is_push = (kind == KIND_PUSH);
		in_op.last    = last && (kind == KIND_PUSH);
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			ent_op_q[wr_ptr_q]  <= in_op;
			ent_val_q[wr_ptr_q] <= value[VW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (q_take) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
			end
			case ({wr_en, q_take})
				2'b10:   cnt_q <= cnt_q + QCW'(1);
				2'b01:   cnt_q <= cnt_q - QCW'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

FILE: rtl/spoc_back.sv
// Back part: sequencer that loads the pop list, pushes onto the stack and
// pops while the top matches, then registers the result. Uses spoc_pkg, spoc_ram.
module spoc_back import spoc_pkg::*; #(
	parameter int MAX_ELEMENTS = 64,
	parameter int VW           = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  op_t           q_op,
	input  logic [VW-1:0] q_value,
	output logic          q_take,
	output logic          out_valid,
	input  logic          out_stall,
	output logic          order_valid,
	output logic          overflow
);

	localparam int AW = $clog2(MAX_ELEMENTS);
	localparam int CW = $clog2(MAX_ELEMENTS + 2);
	localparam logic [CW-1:0] MAX_C = CW'(MAX_ELEMENTS);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_CMP  = 1'b1;

	logic          state_q, state_d;
	logic [CW-1:0] pop_loaded_q, pop_loaded_d;
	logic [CW-1:0] pop_next_q, pop_next_d;
	logic [CW-1:0] depth_q, depth_d;
	logic [CW-1:0] push_total_q, push_total_d;
	logic          ovf_q, ovf_d;
	logic          use_ram_q, use_ram_d;
	logic          last_q, last_d;
	logic [VW-1:0] top_q, top_d;
	logic          out_valid_q;
	logic          order_valid_q;
	logic          overflow_q;
	logic          res_load;
	logic          res_order_valid;

	logic          pop_we;
	logic          lifo_we;
	logic [VW-1:0] pop_rdata;
	logic [VW-1:0] lifo_rdata;
	logic [VW-1:0] cur_top;
	logic          match;
	logic          out_free;
	logic [CW-1:0] lifo_top_idx;

	spoc_ram #(.WIDTH(VW), .DEPTH(MAX_ELEMENTS)) u_pop_ram (
		.clk   (clk),
		.we    (pop_we),
		.waddr (pop_loaded_q[AW-1:0]),
		.wdata (q_value),
		.raddr (pop_next_d[AW-1:0]),
		.rdata (pop_rdata)
	);

	spoc_ram #(.WIDTH(VW), .DEPTH(MAX_ELEMENTS)) u_lifo_ram (
		.clk   (clk),
		.we    (lifo_we),
		.waddr (depth_q[AW-1:0]),
		.wdata (q_value),
		.raddr (lifo_top_idx[AW-1:0]),
		.rdata (lifo_rdata)
	);

	assign lifo_top_idx = depth_d - CW'(1);
	assign cur_top      = use_ram_q ? lifo_rdata : top_q;
	assign match        = (depth_q != '0) && (pop_next_q < pop_loaded_q) &&
	                      (cur_top == pop_rdata);
	assign out_free     = !out_valid_q || !out_stall;
	assign res_order_valid = !ovf_q && (depth_q == '0) && (pop_next_q == pop_loaded_q) &&
	                         (push_total_q == pop_loaded_q);

	always_comb begin
		state_d      = state_q;
		pop_loaded_d = pop_loaded_q;
		pop_next_d   = pop_next_q;
		depth_d      = depth_q;
		push_total_d = push_total_q;
		ovf_d        = ovf_q;
		use_ram_d    = use_ram_q;
		last_d       = last_q;
		top_d        = top_q;
		q_take       = 1'b0;
		pop_we       = 1'b0;
		lifo_we      = 1'b0;
		res_load     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_take = 1'b1;
					if (!q_op.is_push) begin
						if (pop_loaded_q < MAX_C) begin
							pop_we       = 1'b1;
							pop_loaded_d = pop_loaded_q + CW'(1);
						end else begin
							ovf_d = 1'b1;
						end
					end else begin
						if (depth_q < MAX_C) begin
							lifo_we   = 1'b1;
							depth_d   = depth_q + CW'(1);
							top_d     = q_value;
							use_ram_d = 1'b0;
						end else begin
							ovf_d = 1'b1;
						end
						if (push_total_q <= MAX_C) begin
							push_total_d = push_total_q + CW'(1);
						end
						last_d  = q_op.last;
						state_d = ST_CMP;
					end
				end
			end
			ST_CMP: begin
				if (match) begin
					depth_d    = depth_q - CW'(1);
					pop_next_d = pop_next_q + CW'(1);
					use_ram_d  = 1'b1;
				end else if (!last_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					res_load     = 1'b1;
					pop_loaded_d = '0;
					pop_next_d   = '0;
					depth_d      = '0;
					push_total_d = '0;
					ovf_d        = 1'b0;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pop_loaded_q <= '0;
			pop_next_q   <= '0;
			depth_q      <= '0;
			push_total_q <= '0;
			ovf_q        <= 1'b0;
			use_ram_q    <= 1'b0;
			last_q       <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			pop_loaded_q <= pop_loaded_d;
			pop_next_q   <= pop_next_d;
			depth_q      <= depth_d;
			push_total_q <= push_total_d;
			ovf_q        <= ovf_d;
			use_ram_q    <= use_ram_d;
			last_q       <= last_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_d;
		if (res_load) begin
			order_valid_q <= res_order_valid;
			overflow_q    <= ovf_q;
		end
	end

	assign out_valid   = out_valid_q;
	assign order_valid = order_valid_q;
	assign overflow    = overflow_q;

endmodule

FILE: rtl/stack_pop_order_checker.sv
// Top level of the stack pop-order checker: front queue plus back sequencer.
// Uses spoc_pkg, spoc_front, spoc_back.
//
// Input channel (in_valid / in_stall): kind 0 loads the next element of the
// claimed pop list, kind 1 pushes the next element of the push list; last on
// a push asks for the verdict. Output channel (out_valid / out_stall) carries
// one transfer per push marked last: order_valid and overflow.
// A two-entry queue sits between the input and the sequencer. A load is
// stored in the idle state. A push is stored in the idle state, then the
// compare state pops elements while the top matches, comparing the registered
// reads of the two element RAMs, and then goes back to idle.
// The verdict is registered when the compare loop of the last push ends.
// After a verdict all counters are cleared. Reset clears the queue, the
// counters and the output valid flag; the element RAMs need no clearing.
// While the result register is full and stalled, the sequencer holds at the
// final compare and the queue fills, then in_stall rises.
module stack_pop_order_checker import spoc_pkg::*; #(
	parameter int MAX_ELEMENTS = 64,
	parameter int VALUE_BITS   = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [31:0] value,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        order_valid,
	output logic        overflow
);

	localparam int VW = (VALUE_BITS < 32) ? VALUE_BITS : 32;

	logic          q_valid;
	op_t           q_op;
	logic [VW-1:0] q_value;
	logic          q_take;

	spoc_front #(.VW(VW)) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.value    (value),
		.last     (last),
		.q_valid  (q_valid),
		.q_op     (q_op),
		.q_value  (q_value),
		.q_take   (q_take)
	);

	spoc_back #(.MAX_ELEMENTS(MAX_ELEMENTS), .VW(VW)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_op        (q_op),
		.q_value     (q_value),
		.q_take      (q_take),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.order_valid (order_valid),
		.overflow    (overflow)
	);

	a_take_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		q_take |-> q_valid)
		else $error("Sequencer took from an empty queue.");

	a_valid_not_overflowed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && order_valid |-> !overflow)
		else $error("Legal order reported together with overflow.");

	a_load_gives_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		q_take && !q_op.is_push |=> !$rose(out_valid))
		else $error("A load transfer produced a result.");

endmodule

FILE: tb/sv/tb_stack_pop_order_checker.sv
`timescale 1ns / 100ps
// Self-checking testbench of stack_pop_order_checker: directed table, then random checks.
// Depends on spoc_pkg and the RTL of the checker; verdicts are predicted in the bench itself.
module tb_stack_pop_order_checker;
	import spoc_pkg::*;

	localparam int DEPTH = 64;
	localparam int ITEMS = 1400;
	localparam int LONG_HOLD_AT = 1500;
	localparam int LONG_HOLD_LEN = 300;

	typedef struct packed {
		logic order_valid;
		logic overflow;
	} verdict_t;

	typedef struct {
		logic        k;
		logic [31:0] v;
		logic        l;
		bit          typed;
		logic        ev;
		logic        eo;
	} dir_row_t;

	typedef enum int {
		SEQ_LEGAL, SEQ_SWAPPED, SEQ_SHORT, SEQ_LONG, SEQ_POP_OVF,
		SEQ_STACK_OVF, SEQ_EXTRA_PUSH, SEQ_LATE_LOAD, SEQ_NOISE
	} seq_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        kind = KIND_LOAD;
	logic [31:0] value = '0;
	logic        last = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        order_valid;
	logic        overflow;

	logic drv_typed = 1'b0;
	logic drv_ev = 1'b0;
	logic drv_eo = 1'b0;

	logic [31:0] pl_vals [DEPTH];
	logic [31:0] lf_vals [DEPTH];
	int unsigned pl_count = 0;
	int unsigned pl_next = 0;
	int unsigned lf_count = 0;
	int unsigned push_count = 0;
	bit          ovf_seen = 1'b0;

	verdict_t verdicts_due [$];
	verdict_t mon_want;
	verdict_t mon_pred;
	bit       mon_emits;

	int mismatches = 0;
	int items_sent = 0;
	int checks_run = 0;
	int verdicts_seen = 0;
	int legal_seen = 0;
	int overflow_seen = 0;
	bit calm = 1'b0;
	bit steady = 1'b0;

	int rx_cycles = 0;
	int rx_left = 0;

	dir_row_t dir_tab [0:19] = '{
		'{KIND_PUSH, 32'd5,          1'b1, 1'b1, 1'b0, 1'b0},
		'{KIND_LOAD, 32'h8000_0000,  1'b0, 1'b0, 1'b0, 1'b0},
		'{KIND_PUSH, 32'h8000_0000,  1'b1, 1'b1, 1'b1, 1'b0},
		'{KIND_LOAD, 32'h7FFF_FFFF,  1'b1, 1'b0, 1'b0, 1'b0},
		'{KIND_LOAD, 32'hFFFF_FFFF,  1'b0, 1'b0, 1'b0, 1'b0},
		'{KIND_PUSH, 32'hFFFF_FFFF,  1'b0, 1'b0, 1'b0, 1'b0},
		'{KIND_PUSH, 32'h7FFF_FFFF,  1'b1, 1'b0, 1'b0, 1'b0},
		'{KIND_LOAD, 32'd3,          1'b0, 1'b0, 1'b0, 1'b0},
		'{KIND_LOAD, 32'd1,          1'b0, 1'b0, 1'b0, 1'b0},
		'{KIND_LOAD, 32'd2,          1'b0, 1'b0, 1'b0, 1'b0},
		'{KIND_PUSH, 32'd1,          1'b0, 1'b0, 1'b0, 1'b0},
		'{KIND_PUSH, 32'd2,          1'b0, 1'b0, 1'b0, 1'b0},
		'{KIND_PUSH, 32'd3,          1'b1, 1'b0, 1'b0, 1'b0},
		'{KIND_LOAD, 32'd0,          1'b0, 1'b0, 1'b0, 1'b0},
		'{KIND_PUSH, 32'd0,          1'b0, 1'b0, 1'b0, 1'b0},
		'{KIND_PUSH, 32'd0,          1'b1, 1'b0, 1'b0, 1'b0},
		'{KIND_PUSH, 32'd9,          1'b0, 1'b0, 1'b0, 1'b0},
		'{KIND_LOAD, 32'd9,          1'b1, 1'b0, 1'b0, 1'b0},
		'{KIND_PUSH, 32'd4,          1'b1, 1'b0, 1'b0, 1'b0},
		'{KIND_PUSH, 32'h5555_AAAA,  1'b1, 1'b1, 1'b0, 1'b0}
	};

	stack_pop_order_checker #(
		.MAX_ELEMENTS(DEPTH),
		.VALUE_BITS  (32)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.value      (value),
		.last       (last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.order_valid(order_valid),
		.overflow   (overflow)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic track_item(input logic k, input logic [31:0] v, input logic l,
			output bit emits, output verdict_t got);
		emits = 1'b0;
		got = '0;
		if (k == KIND_LOAD) begin
			if (pl_count < DEPTH) begin
				pl_vals[pl_count] = v;
				pl_count++;
			end else begin
				ovf_seen = 1'b1;
			end
			return;
		end
		if (lf_count < DEPTH) begin
			lf_vals[lf_count] = v;
			lf_count++;
		end else begin
			ovf_seen = 1'b1;
		end
		if (push_count <= DEPTH)
			push_count++;
		while (lf_count > 0 && pl_next < pl_count && lf_vals[lf_count - 1] == pl_vals[pl_next]) begin
			lf_count--;
			pl_next++;
		end
		if (!l)
			return;
		emits = 1'b1;
		got.order_valid = !ovf_seen && lf_count == 0 && pl_next == pl_count &&
			push_count == pl_count;
		got.overflow = ovf_seen;
		pl_count = 0;
		pl_next = 0;
		lf_count = 0;
		push_count = 0;
		ovf_seen = 1'b0;
	endtask

	// Output check first, then prediction of the input transfer at the same edge.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			verdicts_seen++;
			if (order_valid === 1'b1)
				legal_seen++;
			if (overflow === 1'b1)
				overflow_seen++;
			if (verdicts_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected verdict order_valid=%b overflow=%b",
						$realtime, order_valid, overflow);
			end else begin
				mon_want = verdicts_due.pop_front();
				if (mon_want.order_valid !== order_valid || mon_want.overflow !== overflow) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: verdict %0d expected order_valid=%b overflow=%b, got %b %b",
							$realtime, verdicts_seen, mon_want.order_valid, mon_want.overflow,
							order_valid, overflow);
				end
			end
		end
		if (arst_n && in_valid && !in_stall) begin
			track_item(kind, value, last, mon_emits, mon_pred);
			if (mon_emits) begin
				if (drv_typed)
					verdicts_due.insert(verdicts_due.size(),
						verdict_t'{order_valid: drv_ev, overflow: drv_eo});
				else
					verdicts_due.insert(verdicts_due.size(), mon_pred);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			rx_cycles <= rx_cycles + 1;
			if (rx_cycles == LONG_HOLD_AT) begin
				out_stall <= 1'b1;
				rx_left <= LONG_HOLD_LEN;
			end else if (rx_left > 1) begin
				rx_left <= rx_left - 1;
			end else if (rx_left == 1) begin
				rx_left <= 0;
				out_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				rx_left <= $urandom_range(1, 6);
			end
		end
	end

	task automatic offer(input logic k, input logic [31:0] v, input logic l,
			input bit typed = 1'b0, input logic ev = 1'b0, input logic eo = 1'b0);
		int gap;
		gap = 0;
		if (!calm && !steady && $urandom_range(0, 4) == 0)
			gap = $urandom_range(1, 6);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		value <= v;
		last <= l;
		drv_typed <= typed;
		drv_ev <= ev;
		drv_eo <= eo;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		items_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (verdicts_due.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_value();
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return $urandom_range(0, 7);
		if (r < 8)
			return $urandom;
		if (r == 8)
			return 32'h8000_0000 | $urandom_range(0, 3);
		return 32'hFFFF_FFFF - $urandom_range(0, 3);
	endfunction

	task automatic run_check();
		logic [31:0] pushes [$];
		logic [31:0] pops [$];
		logic [31:0] stk [$];
		logic [31:0] tmp;
		seq_mode_t   mode;
		int          n;
		int          r;
		int          a;
		int          b;
		int          j;
		r = $urandom_range(0, 99);
		mode = r < 50 ? SEQ_LEGAL : r < 60 ? SEQ_SWAPPED : r < 66 ? SEQ_SHORT :
			r < 72 ? SEQ_LONG : r < 75 ? SEQ_POP_OVF : r < 78 ? SEQ_STACK_OVF :
			r < 81 ? SEQ_EXTRA_PUSH : r < 88 ? SEQ_LATE_LOAD : SEQ_NOISE;
		steady = ($urandom_range(0, 3) == 0);
		if (mode == SEQ_NOISE) begin
			repeat ($urandom_range(1, 6))
				offer(1'($urandom_range(0, 1)), $urandom, 1'b0);
			offer(KIND_PUSH, $urandom, 1'b1);
			return;
		end
		if (mode == SEQ_STACK_OVF) begin
			repeat ($urandom_range(0, 3))
				pops.insert(pops.size(), pick_value());
			repeat (DEPTH + 1 + pops.size() + $urandom_range(0, 2))
				pushes.insert(pushes.size(), pick_value());
		end else if (mode == SEQ_EXTRA_PUSH) begin
			repeat (DEPTH) begin
				tmp = pick_value();
				pushes.insert(pushes.size(), tmp);
				pops.insert(pops.size(), tmp);
			end
			repeat ($urandom_range(1, 3))
				pushes.insert(pushes.size(), pick_value());
		end else begin
			n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, DEPTH) : $urandom_range(1, 10);
			if (mode == SEQ_POP_OVF)
				n = $urandom_range(1, 4);
			repeat (n)
				pushes.insert(pushes.size(), pick_value());
			foreach (pushes[i]) begin
				stk.insert(stk.size(), pushes[i]);
				repeat ($urandom_range(0, stk.size())) begin
					pops.insert(pops.size(), stk[$]);
					stk.delete(stk.size() - 1);
				end
			end
			while (stk.size() != 0) begin
				pops.insert(pops.size(), stk[$]);
				stk.delete(stk.size() - 1);
			end
			case (mode)
				SEQ_SWAPPED: begin
					if (pops.size() >= 2) begin
						a = $urandom_range(0, pops.size() - 1);
						b = $urandom_range(0, pops.size() - 1);
						tmp = pops[a];
						pops[a] = pops[b];
						pops[b] = tmp;
					end
				end
				SEQ_SHORT: pops.delete($urandom_range(0, pops.size() - 1));
				SEQ_LONG: pops.insert($urandom_range(0, pops.size()), pick_value());
				SEQ_POP_OVF: begin
					while (pops.size() < DEPTH + 1 + $urandom_range(0, 3))
						pops.insert(pops.size(), pick_value());
				end
				default: ;
			endcase
		end
		j = 0;
		if (mode != SEQ_LATE_LOAD) begin
			for (j = 0; j < pops.size(); j++)
				offer(KIND_LOAD, pops[j], 1'($urandom_range(0, 1)));
		end
		foreach (pushes[i]) begin
			if (mode == SEQ_LATE_LOAD) begin
				while (j < pops.size() && (i == pushes.size() - 1 || $urandom_range(0, 1) == 0)) begin
					offer(KIND_LOAD, pops[j], 1'($urandom_range(0, 1)));
					j++;
				end
			end
			offer(KIND_PUSH, pushes[i], i == pushes.size() - 1);
		end
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i])
			offer(dir_tab[i].k, dir_tab[i].v, dir_tab[i].l, dir_tab[i].typed,
				dir_tab[i].ev, dir_tab[i].eo);
		settle();
		while (items_sent < ITEMS) begin
			checks_run++;
			if (checks_run == 120)
				settle();
			if (items_sent >= ITEMS - 200)
				calm = 1'b1;
			run_check();
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (verdicts_due.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		$display("Sent %0d input transfers in %0d checks; %0d verdicts, %0d legal, %0d overflow.",
			items_sent, checks_run, verdicts_seen, legal_seen, overflow_seen);
		$display("Mismatches: %0d.", mismatches);
		if (mismatches == 0 && verdicts_due.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timed out with %0d verdicts outstanding.", verdicts_due.size());
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
